// ===== rtl/core/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
package tcw_pkg;

	localparam logic [1:0] OP_PRINT = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [7:0] CH_NEWLINE  = 8'd10;
	localparam logic [7:0] CH_TAB      = 8'd9;
	localparam logic [7:0] CH_BLANK    = 8'h20;
	localparam logic [7:0] RESET_COLOR = 8'h07;
	localparam logic [8:0] TAB_STEP    = 9'd8;
	localparam logic [8:0] TAB_MASK    = 9'h1F8;

	// row * cols + col always fits here for up to 255 x 255 cells
	localparam int POS_W = 16;

	typedef struct packed {
		logic [1:0]  operation;
		logic        first_of_string;
		logic [7:0]  start_col;
		logic [7:0]  home_row;
		logic [7:0]  char_code;
		logic [3:0]  fg_nibble;
		logic [3:0]  bg_nibble;
		logic        use_global_bg;
		logic [10:0] read_index;
	} req_t;

	typedef struct packed {
		logic        wrote;
		logic [10:0] cell_index;
		logic [15:0] cell_value;
		logic        scrolled;
		logic [15:0] read_data;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_SCROLL_COPY,
		ST_SCROLL_FILL,
		ST_MUL,
		ST_WRITE,
		ST_READ,
		ST_CLEAR,
		ST_EMIT
	} state_t;

endpackage

// ===== rtl/core/text_console_writer_unit.sv =====
// Text console writer: character-cell screen store with print, read, clear.
//
//  channel | valid     | ready     | beat
//  --------+-----------+-----------+------------------------------------
//  request | req_valid | req_ready | req  (tcw_pkg::req_t)
//  result  | rsp_valid | rsp_ready | rsp  (tcw_pkg::rsp_t)
//  config  | cfg_valid | cfg_ready | cfg_data (default color, 8 bits)
//
// A print that scrolls and a clear both walk the screen RAM through its single
// write port, one cell per cycle; the scroll's blank fill waits while the last
// copy write is still pending.
// Reset: a fill pass writes blanks in color 7 into every cell; no request is
// taken until it ends. Config writes are always taken.
// Stalls: a result waiting on rsp_ready does not block the next request; the
// sequencer only holds in its result state if the previous beat is still out.
module text_console_writer_unit #(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  tcw_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output tcw_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [7:0]    cfg_data
);

	localparam int CELLS = COLS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam logic [AW-1:0] LAST_CELL   = AW'(CELLS - 1);
	localparam logic [AW-1:0] COPY_FIRST  = AW'(COLS);
	localparam logic [AW-1:0] FILL_FIRST  = AW'(CELLS - COLS);
	localparam logic [8:0]    COLS_9      = 9'(COLS);
	localparam logic [7:0]    ROWS_8      = 8'(ROWS);
	localparam logic [7:0]    LAST_ROW    = 8'(ROWS - 1);

	tcw_pkg::state_t state_q, state_d;

	// control state
	logic [AW-1:0] sw_q;         // sweep pointer for fill, clear, scroll copy
	logic          cp_pend_s1;   // scroll copy write due in the cycle after its read
	logic [7:0]    col_q, row_q, org_q;
	logic [7:0]    cfg_q;
	logic          rsp_valid_q;

	// payload
	tcw_pkg::req_t     req_q;
	tcw_pkg::rsp_t     res_q, rsp_q;
	tcw_pkg::rsp_t     res_d;
	logic [AW-1:0]     cp_addr_s1;
	logic [tcw_pkg::POS_W-1:0] pos_q;
	logic [15:0]       cell_q;

	// RAM port
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [15:0]   ram_wdata, ram_rdata;

	logic fill_go;
	logic emit_go;

	// decode of the latched request
	logic [7:0] org_ld, col_ld, row_ld;
	logic       is_newline, is_tab, need_scroll, read_in_range;
	logic [8:0] ctrl_col9;
	logic [7:0] ctrl_row;
	logic [7:0] wrap_col, wrap_row;
	logic [8:0] col_inc9;
	logic [7:0] inc_col, inc_row;

	function automatic logic [7:0] next_row(input logic [7:0] r);
		return (r == 8'hFF) ? r : r + 8'd1;
	endfunction

	tcw_ram #(
		.WIDTH(16),
		.DEPTH(CELLS)
	) u_screen (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// position math
	always_comb begin
		org_ld = req_q.first_of_string ? req_q.start_col : org_q;
		col_ld = req_q.first_of_string ? req_q.start_col : col_q;
		row_ld = req_q.first_of_string ? req_q.home_row : row_q;
		is_newline  = (req_q.char_code == tcw_pkg::CH_NEWLINE);
		is_tab      = (req_q.char_code == tcw_pkg::CH_TAB);
		need_scroll = (row_ld >= ROWS_8);
		read_in_range = (32'(req_q.read_index) < CELLS);

		// newline and tab: column before the wrap rule
		if (is_newline) begin
			ctrl_col9 = {1'b0, org_ld};
			ctrl_row  = next_row(row_ld);
		end else begin
			ctrl_col9 = ({1'b0, col_ld} + tcw_pkg::TAB_STEP) & tcw_pkg::TAB_MASK;
			ctrl_row  = row_ld;
		end
		if (ctrl_col9 >= COLS_9) begin
			wrap_col = 8'd0;
			wrap_row = next_row(ctrl_row);
		end else begin
			wrap_col = ctrl_col9[7:0];
			wrap_row = ctrl_row;
		end

		// printed character: advance one column, then wrap
		col_inc9 = {1'b0, col_q} + 9'd1;
		if (col_inc9 >= COLS_9) begin
			inc_col = 8'd0;
			inc_row = next_row(row_q);
		end else begin
			inc_col = col_inc9[7:0];
			inc_row = row_q;
		end
	end

	assign fill_go = !cp_pend_s1 && (state_q == tcw_pkg::ST_INIT ||
		state_q == tcw_pkg::ST_CLEAR || state_q == tcw_pkg::ST_SCROLL_FILL);
	assign emit_go = (state_q == tcw_pkg::ST_EMIT) && (!rsp_valid_q || rsp_ready);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tcw_pkg::ST_INIT: begin
				if (sw_q == LAST_CELL) state_d = tcw_pkg::ST_IDLE;
			end
			tcw_pkg::ST_IDLE: begin
				if (req_valid) state_d = tcw_pkg::ST_DECODE;
			end
			tcw_pkg::ST_DECODE: begin
				case (req_q.operation)
					tcw_pkg::OP_PRINT: begin
						if (is_newline || is_tab) state_d = tcw_pkg::ST_EMIT;
						else if (need_scroll)     state_d = tcw_pkg::ST_SCROLL_COPY;
						else                      state_d = tcw_pkg::ST_MUL;
					end
					tcw_pkg::OP_READ: begin
						state_d = read_in_range ? tcw_pkg::ST_READ : tcw_pkg::ST_EMIT;
					end
					tcw_pkg::OP_CLEAR: state_d = tcw_pkg::ST_CLEAR;
					default:           state_d = tcw_pkg::ST_EMIT;
				endcase
			end
			tcw_pkg::ST_SCROLL_COPY: begin
				if (sw_q == LAST_CELL) state_d = tcw_pkg::ST_SCROLL_FILL;
			end
			tcw_pkg::ST_SCROLL_FILL: begin
				if (fill_go && sw_q == LAST_CELL) state_d = tcw_pkg::ST_MUL;
			end
			tcw_pkg::ST_MUL:   state_d = tcw_pkg::ST_WRITE;
			tcw_pkg::ST_WRITE: state_d = tcw_pkg::ST_EMIT;
			tcw_pkg::ST_READ:  state_d = tcw_pkg::ST_EMIT;
			tcw_pkg::ST_CLEAR: begin
				if (sw_q == LAST_CELL) state_d = tcw_pkg::ST_EMIT;
			end
			tcw_pkg::ST_EMIT: begin
				if (emit_go) state_d = tcw_pkg::ST_IDLE;
			end
			default: state_d = tcw_pkg::ST_INIT;
		endcase
	end

	// outputs of the sequencer: RAM controls and request ready
	always_comb begin
		req_ready = (state_q == tcw_pkg::ST_IDLE);
		ram_we    = 1'b0;
		ram_waddr = sw_q;
		ram_wdata = {cfg_q, tcw_pkg::CH_BLANK};
		ram_raddr = (state_q == tcw_pkg::ST_SCROLL_COPY) ? sw_q : AW'(req_q.read_index);
		if (cp_pend_s1) begin
			ram_we    = 1'b1;
			ram_waddr = cp_addr_s1;
			ram_wdata = ram_rdata;
		end else if (fill_go) begin
			ram_we = 1'b1;
			if (state_q == tcw_pkg::ST_INIT) begin
				ram_wdata = {tcw_pkg::RESET_COLOR, tcw_pkg::CH_BLANK};
			end
		end else if (state_q == tcw_pkg::ST_WRITE && {1'b0, col_q} < COLS_9) begin
			ram_we    = 1'b1;
			ram_waddr = pos_q[AW-1:0];
			ram_wdata = cell_q;
		end
	end

	// result fields as they build up over the sequence
	always_comb begin
		res_d = res_q;
		case (state_q)
			tcw_pkg::ST_DECODE: begin
				res_d          = '0;
				res_d.scrolled = (req_q.operation == tcw_pkg::OP_PRINT) &&
					!is_newline && !is_tab && need_scroll;
			end
			tcw_pkg::ST_WRITE: begin
				if ({1'b0, col_q} < COLS_9) begin
					res_d.wrote      = 1'b1;
					res_d.cell_index = pos_q[10:0];
					res_d.cell_value = cell_q;
				end
			end
			tcw_pkg::ST_READ: res_d.read_data = ram_rdata;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tcw_pkg::ST_INIT;
			sw_q        <= '0;
			cp_pend_s1  <= 1'b0;
			col_q       <= '0;
			row_q       <= '0;
			org_q       <= '0;
			cfg_q       <= tcw_pkg::RESET_COLOR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			cp_pend_s1 <= (state_q == tcw_pkg::ST_SCROLL_COPY);
			if (cfg_valid) cfg_q <= cfg_data;

			if (emit_go)        rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;

			case (state_q)
				tcw_pkg::ST_INIT, tcw_pkg::ST_CLEAR, tcw_pkg::ST_SCROLL_FILL: begin
					if (fill_go && sw_q != LAST_CELL) sw_q <= sw_q + AW'(1);
					if (state_q == tcw_pkg::ST_CLEAR && sw_q == LAST_CELL) begin
						col_q <= '0;
						row_q <= '0;
					end
				end
				tcw_pkg::ST_SCROLL_COPY: begin
					sw_q <= (sw_q == LAST_CELL) ? FILL_FIRST : sw_q + AW'(1);
				end
				tcw_pkg::ST_DECODE: begin
					case (req_q.operation)
						tcw_pkg::OP_PRINT: begin
							org_q <= org_ld;
							if (is_newline || is_tab) begin
								col_q <= wrap_col;
								row_q <= wrap_row;
							end else begin
								col_q <= col_ld;
								row_q <= need_scroll ? LAST_ROW : row_ld;
								sw_q  <= COPY_FIRST;
							end
						end
						tcw_pkg::OP_CLEAR: sw_q <= '0;
						default: ;
					endcase
				end
				tcw_pkg::ST_WRITE: begin
					col_q <= inc_col;
					row_q <= inc_row;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == tcw_pkg::ST_IDLE && req_valid) req_q <= req;
		cp_addr_s1 <= sw_q - COPY_FIRST;
		if (emit_go) rsp_q <= res_q;
		res_q <= res_d;

		if (state_q == tcw_pkg::ST_MUL) begin
			pos_q  <= tcw_pkg::POS_W'(row_q) * tcw_pkg::POS_W'(COLS) +
				tcw_pkg::POS_W'(col_q);
			cell_q <= {req_q.use_global_bg ? cfg_q[7:4] : req_q.bg_nibble,
				req_q.fg_nibble, req_q.char_code};
		end
	end

	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef NO_ASSERTIONS
	// every RAM write lands inside the screen
	a_waddr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (32'(ram_waddr) < CELLS))
		else $error("screen write address out of range");

	// a cell is only written on a row that exists
	a_write_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcw_pkg::ST_WRITE) |-> (row_q < ROWS_8))
		else $error("print on a row past the screen");

	// a copy write comes in the cycle after a copy read
	a_copy_trail: assert property (@(posedge clk) disable iff (!arst_n)
		cp_pend_s1 |-> ($past(state_q) == tcw_pkg::ST_SCROLL_COPY))
		else $error("scroll copy write without a preceding read");

	// a result is never loaded while the previous beat is still stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_ready) |-> !emit_go)
		else $error("result overwritten while stalled");
`endif

endmodule

// ===== rtl/core/tcw_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
